// ===== rtl/core/circ_pkg.sv =====
`timescale 1ns / 1ps

package circ_pkg;

  localparam int COORD_W   = 16;
  localparam int RAD_W     = 12;
  localparam int OFF_W     = 13;
  localparam int ERR_W     = 15;
  localparam int PIX_W     = 17;
  localparam int COLOR_W   = 16;
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PT_W      = 3;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 13'd128;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 13'd160;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [PT_W-1:0] PT_LAST = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] centre_col;
    logic signed [COORD_W-1:0] centre_row;
    logic signed [OFF_W-1:0]   major;
    logic signed [OFF_W-1:0]   minor;
    logic [COLOR_W-1:0]        color;
    logic                      done;
    logic                      idle;
  } step_desc_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } screen_cfg_t;

endpackage

// ===== rtl/core/midpoint_circle_outline_top.sv =====
// Load item: no result. Step item: eight points, one per cycle while
// out_stall is low, the first held in the step queue and then registered
// at the output. The single point emitter ends a step's points before it
// pops the next step; a step with no circle loaded gives one result.
// Reset (rst_n low, synchronous) drops the circle, empties the two-entry
// step queue and sets the screen size to 128 x 160.
`timescale 1ns / 1ps

module midpoint_circle_outline_top
  import circ_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic [RAD_W-1:0]          in_radius,
  input  logic [COLOR_W-1:0]        in_color,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PIX_W-1:0]   out_pixel_x,
  output logic signed [PIX_W-1:0]   out_pixel_y,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_on_screen,
  output logic                      out_last_point,
  output logic                      out_circle_done,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SIZE_W-1:0]         cfg_data
);

  screen_cfg_t screen_r;
  logic        q_full, push, pop, head_valid;
  step_desc_t  push_desc, head_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r.width  <= SCREEN_WIDTH_RST;
      screen_r.height <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_r.width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_r.height <= cfg_data;
        default:           screen_r        <= screen_r;
      endcase
    end
  end

  circ_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_color    (in_color),
    .q_full      (q_full),
    .push        (push),
    .push_desc   (push_desc)
  );

  circ_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  circ_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .screen          (screen_r),
    .head_valid      (head_valid),
    .head_desc       (head_desc),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_on_screen   (out_on_screen),
    .out_last_point  (out_last_point),
    .out_circle_done (out_circle_done)
  );

endmodule

// ===== rtl/core/circ_front.sv =====
`timescale 1ns / 1ps

module circ_front
  import circ_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic [RAD_W-1:0]          in_radius,
  input  logic [COLOR_W-1:0]        in_color,
  input  logic                      q_full,
  output logic                      push,
  output step_desc_t                push_desc
);

  logic signed [COORD_W-1:0] centre_col_r;
  logic signed [COORD_W-1:0] centre_row_r;
  logic signed [OFF_W-1:0]   major_r, major_nxt;
  logic signed [OFF_W-1:0]   minor_r, minor_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic [COLOR_W-1:0]        color_r;
  logic                      active_r, active_nxt;

  logic                      accept;
  logic signed [ERR_W-1:0]   maj_e, min_e, err_mid;
  logic signed [OFF_W-1:0]   minor_mid;
  logic                      step_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_action == ACT_STEP);

  assign maj_e = ERR_W'(major_r);
  assign min_e = ERR_W'(minor_r);

  // midpoint update: maybe grow minor, then maybe shrink major
  always_comb begin
    if (err_r <= 0) begin
      minor_mid = minor_r + OFF_W'(1);
      err_mid   = err_r + (min_e <<< 1) + ERR_W'(3);
    end else begin
      minor_mid = minor_r;
      err_mid   = err_r;
    end
    if (err_mid > 0) begin
      major_nxt = major_r - OFF_W'(1);
      err_nxt   = err_mid - (maj_e <<< 1) + ERR_W'(1);
    end else begin
      major_nxt = major_r;
      err_nxt   = err_mid;
    end
    minor_nxt = minor_mid;
    step_done = major_nxt < minor_nxt;
    active_nxt = active_r && !step_done;
  end

  always_comb begin
    push_desc.centre_col = centre_col_r;
    push_desc.centre_row = centre_row_r;
    push_desc.major      = major_r;
    push_desc.minor      = minor_r;
    push_desc.color      = color_r;
    push_desc.done       = step_done;
    push_desc.idle       = !active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (accept) begin
      if (in_action == ACT_LOAD) begin
        active_r <= 1'b1;
      end else begin
        active_r <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_action == ACT_LOAD) begin
        centre_col_r <= in_center_x;
        centre_row_r <= in_center_y;
        major_r      <= $signed({1'b0, in_radius});
        minor_r      <= '0;
        err_r        <= '0;
        color_r      <= in_color;
      end else if (active_r) begin
        major_r <= major_nxt;
        minor_r <= minor_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/circ_queue.sv =====
`timescale 1ns / 1ps

module circ_queue
  import circ_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  step_desc_t push_desc,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output step_desc_t head_desc
);

  step_desc_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/core/circ_back.sv =====
`timescale 1ns / 1ps

module circ_back
  import circ_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  screen_cfg_t             screen,
  input  logic                    head_valid,
  input  step_desc_t              head_desc,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0]      out_pixel_color,
  output logic                    out_on_screen,
  output logic                    out_last_point,
  output logic                    out_circle_done
);

  logic [PT_W-1:0]         pt_r;
  logic                    valid_r;
  logic signed [PIX_W-1:0] px_r, py_r;
  logic [COLOR_W-1:0]      color_r;
  logic                    on_r, last_r, done_r;

  logic                    load;
  logic                    last;
  logic signed [PIX_W-1:0] maj, mnr, cx, cy, dx, dy, px, py;
  logic                    on;

  assign load = head_valid && (!valid_r || !out_stall);
  assign last = head_desc.idle || (pt_r == PT_LAST);
  assign pop  = load && last;

  assign maj = PIX_W'(head_desc.major);
  assign mnr = PIX_W'(head_desc.minor);
  assign cx  = PIX_W'(head_desc.centre_col);
  assign cy  = PIX_W'(head_desc.centre_row);

  // octant order of the eight mirrored points
  always_comb begin
    unique case (pt_r)
      3'd0:    begin dx =  maj; dy =  mnr; end
      3'd1:    begin dx =  mnr; dy =  maj; end
      3'd2:    begin dx = -mnr; dy =  maj; end
      3'd3:    begin dx = -maj; dy =  mnr; end
      3'd4:    begin dx = -maj; dy = -mnr; end
      3'd5:    begin dx = -mnr; dy = -maj; end
      3'd6:    begin dx =  mnr; dy = -maj; end
      default: begin dx =  maj; dy = -mnr; end
    endcase
    px = cx + dx;
    py = cy + dy;
    on = !px[PIX_W-1] && !py[PIX_W-1]
         && (px[PIX_W-2:0] < {{(PIX_W-1-SIZE_W){1'b0}}, screen.width})
         && (py[PIX_W-2:0] < {{(PIX_W-1-SIZE_W){1'b0}}, screen.height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pt_r    <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pt_r    <= last ? '0 : pt_r + PT_W'(1);
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head_desc.idle) begin
        px_r    <= '0;
        py_r    <= '0;
        color_r <= '0;
        on_r    <= 1'b0;
        last_r  <= 1'b1;
        done_r  <= 1'b1;
      end else begin
        px_r    <= px;
        py_r    <= py;
        color_r <= head_desc.color;
        on_r    <= on;
        last_r  <= last;
        done_r  <= last && head_desc.done;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = color_r;
  assign out_on_screen   = on_r;
  assign out_last_point  = last_r;
  assign out_circle_done = done_r;

endmodule
